### hw/rtl/cbif_pkg.sv
`default_nettype none

package cbif_pkg;

   // Fraction bits of the box coordinates.
   localparam int COORD_FRAC_BITS = 8;

   localparam int COORD_W = 24;
   localparam int SIZE_W  = 25;
   localparam int LABEL_W = 16;
   localparam int CROP_W  = 16;
   localparam int THR_W   = 17;

   // IoU threshold after reset: 0.5 in Q1.16.
   localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

   // Step that the datapath performs in a cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_GEOM,
      OP_INTER,
      OP_BOX,
      OP_CROP,
      OP_UNION,
      OP_TLO,
      OP_THI,
      OP_CMP
   } cbif_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GEOM,
      ST_INTER,
      ST_BOX,
      ST_CROP,
      ST_UNION,
      ST_TLO,
      ST_THI,
      ST_CMP,
      ST_DECIDE
   } cbif_state_type;

   typedef struct packed {
      logic        load_in;
      cbif_op_type op;
      logic        load_out;
      logic        fallback;
   } cbif_cmd_type;

   typedef struct packed {
      logic nobox;
      logic last;
      logic keep;
   } cbif_status_type;

endpackage

`default_nettype wire

### hw/rtl/cbif_req_if.sv
`default_nettype none

interface cbif_req_if;
   logic                                valid;
   logic                                ready;
   logic [cbif_pkg::COORD_W-1:0]        box_x;
   logic [cbif_pkg::COORD_W-1:0]        box_y;
   logic [cbif_pkg::COORD_W-1:0]        box_w;
   logic [cbif_pkg::COORD_W-1:0]        box_h;
   logic [cbif_pkg::LABEL_W-1:0]        box_label;
   logic [cbif_pkg::CROP_W-1:0]         crop_x;
   logic [cbif_pkg::CROP_W-1:0]         crop_y;
   logic [cbif_pkg::CROP_W-1:0]         crop_w;
   logic [cbif_pkg::CROP_W-1:0]         crop_h;
   logic                                last_box;
   logic                                no_box;

   modport source (
      output valid, box_x, box_y, box_w, box_h, box_label,
             crop_x, crop_y, crop_w, crop_h, last_box, no_box,
      input  ready
   );
   modport sink (
      input  valid, box_x, box_y, box_w, box_h, box_label,
             crop_x, crop_y, crop_w, crop_h, last_box, no_box,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/cbif_rsp_if.sv
`default_nettype none

interface cbif_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [cbif_pkg::COORD_W-1:0]        out_x;
   logic [cbif_pkg::COORD_W-1:0]        out_y;
   logic signed [cbif_pkg::SIZE_W-1:0]  out_w;
   logic signed [cbif_pkg::SIZE_W-1:0]  out_h;
   logic [cbif_pkg::LABEL_W-1:0]        out_label;
   logic                                image_end;

   modport source (
      output valid, out_x, out_y, out_w, out_h, out_label, image_end,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_w, out_h, out_label, image_end,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/crop_bbox_iou_filter_clip_top.sv
// Requests are taken one at a time: a new request is accepted only once the last one is done.
// A request without a box skips the area, union and compare steps; the single shared 32x32
// multiplier computes five products in turn.
// A result waiting in the output register stalls the block only when the next one is due.
// Reset (synchronous, active high) empties the block, forgets kept boxes, sets threshold 0.5.
`default_nettype none

module crop_bbox_iou_filter_clip_top #(
   parameter int COORD_FRAC_BITS = cbif_pkg::COORD_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cbif_req_if.sink                           req_bus,
   cbif_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [cbif_pkg::THR_W-1:0]    csr_wr_data
);

   // The controller sequences one request at a time through the datapath:
   // geometry, overlap area, box area, crop area, union, the two halves of
   // threshold times union, and finally the compare. The decision to emit a
   // kept box, a fallback box or nothing is taken by the controller, which
   // also tracks whether the current image has kept any box yet.
   cbif_pkg::cbif_cmd_type    cmd;
   cbif_pkg::cbif_status_type status;

   cbif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the captured request, the shared multiplier, the
   // threshold register and the output register that feeds rsp.
   cbif_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .box_x       (req_bus.box_x),
      .box_y       (req_bus.box_y),
      .box_w       (req_bus.box_w),
      .box_h       (req_bus.box_h),
      .box_label   (req_bus.box_label),
      .crop_x      (req_bus.crop_x),
      .crop_y      (req_bus.crop_y),
      .crop_w      (req_bus.crop_w),
      .crop_h      (req_bus.crop_h),
      .last_box    (req_bus.last_box),
      .no_box      (req_bus.no_box),
      .out_x       (rsp_bus.out_x),
      .out_y       (rsp_bus.out_y),
      .out_w       (rsp_bus.out_w),
      .out_h       (rsp_bus.out_h),
      .out_label   (rsp_bus.out_label),
      .image_end   (rsp_bus.image_end)
   );

endmodule

`default_nettype wire

### hw/rtl/cbif_datapath.sv
`default_nettype none

module cbif_datapath #(
   parameter int COORD_FRAC_BITS = cbif_pkg::COORD_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cbif_pkg::cbif_cmd_type              cmd,
   output cbif_pkg::cbif_status_type                status,
   input  wire logic                                csr_wr_en,
   input  wire logic [cbif_pkg::THR_W-1:0]          csr_wr_data,
   input  wire logic [cbif_pkg::COORD_W-1:0]        box_x,
   input  wire logic [cbif_pkg::COORD_W-1:0]        box_y,
   input  wire logic [cbif_pkg::COORD_W-1:0]        box_w,
   input  wire logic [cbif_pkg::COORD_W-1:0]        box_h,
   input  wire logic [cbif_pkg::LABEL_W-1:0]        box_label,
   input  wire logic [cbif_pkg::CROP_W-1:0]         crop_x,
   input  wire logic [cbif_pkg::CROP_W-1:0]         crop_y,
   input  wire logic [cbif_pkg::CROP_W-1:0]         crop_w,
   input  wire logic [cbif_pkg::CROP_W-1:0]         crop_h,
   input  wire logic                                last_box,
   input  wire logic                                no_box,
   output logic [cbif_pkg::COORD_W-1:0]             out_x,
   output logic [cbif_pkg::COORD_W-1:0]             out_y,
   output logic signed [cbif_pkg::SIZE_W-1:0]       out_w,
   output logic signed [cbif_pkg::SIZE_W-1:0]       out_h,
   output logic [cbif_pkg::LABEL_W-1:0]             out_label,
   output logic                                     image_end
);

   localparam int F    = COORD_FRAC_BITS;
   localparam int CW   = cbif_pkg::COORD_W;
   localparam int SZW  = cbif_pkg::SIZE_W;
   localparam int TW   = cbif_pkg::THR_W;
   localparam int CQW  = cbif_pkg::CROP_W + F;              // crop in box format
   localparam int EW   = ((CQW > CW) ? CQW : CW) + 1;       // right and bottom edges
   localparam int SW   = EW + 1;                            // signed extents
   localparam int AW   = 2 * CW;                            // box and overlap areas
   localparam int CAW  = 2 * cbif_pkg::CROP_W;              // crop area in whole pixels
   localparam int CSW  = CAW + 2 * F;
   localparam int UW   = ((CSW > AW) ? CSW : AW) + 1;       // union area
   localparam int UHW  = UW - 32;
   localparam int PLW  = TW + 32;
   localparam int PHW  = TW + UHW;
   localparam int CMPW = TW + UW;

   localparam logic signed [SW-1:0] SAT_MAX = SW'((2 ** (SZW - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_MIN = SW'(-(2 ** (SZW - 1)));

   function automatic logic [SZW-1:0] sat_size(input logic signed [SW-1:0] v);
      logic [SZW-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[SZW-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[SZW-1:0];
      end else begin
         r = v[SZW-1:0];
      end
      return r;
   endfunction

   // Captured request.
   logic [CW-1:0]                   bx_ff, by_ff, bw_ff, bh_ff;
   logic [cbif_pkg::LABEL_W-1:0]    label_ff;
   logic [cbif_pkg::CROP_W-1:0]     cx_ff, cy_ff, cw_ff, ch_ff;
   logic                            last_ff, nobox_ff;

   // Intermediate results.
   logic [CW-1:0]                   ox_ff, oy_ff;
   logic signed [SW-1:0]            iw_ff, ih_ff;
   logic [AW-1:0]                   inter_ff, barea_ff;
   logic [CAW-1:0]                  carea_ff;
   logic [UW-1:0]                   uni_ff, uni_in;
   logic [PLW-1:0]                  plo_ff;
   logic [PHW-1:0]                  phi_ff;
   logic                            keep_ff, keep_in;
   logic [TW-1:0]                   thr_ff;

   // Result register.
   logic [CW-1:0]                   out_x_ff, out_y_ff;
   logic [SZW-1:0]                  out_w_ff, out_h_ff;
   logic [cbif_pkg::LABEL_W-1:0]    out_label_ff;
   logic                            image_end_ff;

   // Geometry.
   logic [CQW-1:0]                  cxq, cyq, cwq, chq;
   logic [EW-1:0]                   bxl, byt, bxr, byb, cxl, cyt, cxr, cyb;
   logic [EW-1:0]                   xa, ya, xb, yb;
   logic signed [SW-1:0]            iw_in, ih_in, fb_w, fb_h;
   logic [CW-1:0]                   ox_in, oy_in;

   assign cxq = CQW'(cx_ff) << F;
   assign cyq = CQW'(cy_ff) << F;
   assign cwq = CQW'(cw_ff) << F;
   assign chq = CQW'(ch_ff) << F;
   assign bxl = EW'(bx_ff);
   assign byt = EW'(by_ff);
   assign bxr = EW'(bx_ff) + EW'(bw_ff);
   assign byb = EW'(by_ff) + EW'(bh_ff);
   assign cxl = EW'(cxq);
   assign cyt = EW'(cyq);
   assign cxr = EW'(cxq) + EW'(cwq);
   assign cyb = EW'(cyq) + EW'(chq);

   assign xa = (cxl > bxl) ? cxl : bxl;
   assign ya = (cyt > byt) ? cyt : byt;
   assign xb = (cxr < bxr) ? cxr : bxr;
   assign yb = (cyb < byb) ? cyb : byb;

   assign iw_in = signed'(SW'(xb)) - signed'(SW'(xa));
   assign ih_in = signed'(SW'(yb)) - signed'(SW'(ya));
   assign ox_in = CW'(xa - cxl);
   assign oy_in = CW'(ya - cyt);

   // Fallback extent; a zero crop size gives minus one pixel.
   assign fb_w = signed'((SW'(cw_ff) - SW'(1)) << F);
   assign fb_h = signed'((SW'(ch_ff) - SW'(1)) << F);

   // One shared multiplier serves all five products.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic        both_pos;

   assign both_pos = (iw_ff > 0) && (ih_ff > 0);

   always_comb begin
      unique case (cmd.op)
         cbif_pkg::OP_INTER: begin
            mul_a = both_pos ? 32'(iw_ff[CW-1:0]) : '0;
            mul_b = both_pos ? 32'(ih_ff[CW-1:0]) : '0;
         end
         cbif_pkg::OP_BOX: begin
            mul_a = 32'(bw_ff);
            mul_b = 32'(bh_ff);
         end
         cbif_pkg::OP_CROP: begin
            mul_a = 32'(cw_ff);
            mul_b = 32'(ch_ff);
         end
         cbif_pkg::OP_TLO: begin
            mul_a = 32'(thr_ff);
            mul_b = uni_ff[31:0];
         end
         cbif_pkg::OP_THI: begin
            mul_a = 32'(thr_ff);
            mul_b = 32'(uni_ff[UW-1:32]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // Union and the division-free IoU test.
   logic [CMPW-1:0] lhs, rhs;

   assign uni_in = UW'(barea_ff) + (UW'(carea_ff) << (2 * F)) - UW'(inter_ff);
   assign lhs    = CMPW'(inter_ff) << 16;
   assign rhs    = CMPW'(plo_ff) + (CMPW'(phi_ff) << 32);
   assign keep_in = (uni_ff == '0) ? (thr_ff == '0) : (lhs >= rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cbif_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         bx_ff    <= box_x;
         by_ff    <= box_y;
         bw_ff    <= box_w;
         bh_ff    <= box_h;
         label_ff <= box_label;
         cx_ff    <= crop_x;
         cy_ff    <= crop_y;
         cw_ff    <= crop_w;
         ch_ff    <= crop_h;
         last_ff  <= last_box;
         nobox_ff <= no_box;
      end
      case (cmd.op)
         cbif_pkg::OP_GEOM: begin
            ox_ff <= ox_in;
            oy_ff <= oy_in;
            iw_ff <= iw_in;
            ih_ff <= ih_in;
         end
         cbif_pkg::OP_INTER: inter_ff <= mul_p[AW-1:0];
         cbif_pkg::OP_BOX:   barea_ff <= mul_p[AW-1:0];
         cbif_pkg::OP_CROP:  carea_ff <= mul_p[CAW-1:0];
         cbif_pkg::OP_UNION: uni_ff   <= uni_in;
         cbif_pkg::OP_TLO:   plo_ff   <= mul_p[PLW-1:0];
         cbif_pkg::OP_THI:   phi_ff   <= mul_p[PHW-1:0];
         cbif_pkg::OP_CMP:   keep_ff  <= keep_in;
         default: begin
         end
      endcase
      if (cmd.load_out) begin
         if (cmd.fallback) begin
            out_x_ff     <= '0;
            out_y_ff     <= '0;
            out_w_ff     <= sat_size(fb_w);
            out_h_ff     <= sat_size(fb_h);
            out_label_ff <= '0;
         end else begin
            out_x_ff     <= ox_ff;
            out_y_ff     <= oy_ff;
            out_w_ff     <= sat_size(iw_ff);
            out_h_ff     <= sat_size(ih_ff);
            out_label_ff <= label_ff;
         end
         // A fallback box only ever closes an image, so this covers both cases.
         image_end_ff <= last_ff;
      end
   end

   assign status.nobox = nobox_ff;
   assign status.last  = last_ff;
   assign status.keep  = keep_ff;

   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_w     = signed'(out_w_ff);
   assign out_h     = signed'(out_h_ff);
   assign out_label = out_label_ff;
   assign image_end = image_end_ff;

endmodule

`default_nettype wire

### hw/rtl/cbif_ctrl.sv
`default_nettype none

module cbif_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output cbif_pkg::cbif_cmd_type           cmd,
   input  wire cbif_pkg::cbif_status_type   status
);

   cbif_pkg::cbif_state_type state_ff, state_in;
   logic any_kept_ff, any_kept_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic emit_kept, emit_fb, need_out, out_free;

   assign emit_kept = !status.nobox && status.keep;
   assign emit_fb   = status.last && !any_kept_ff && !emit_kept;
   assign need_out  = emit_kept || emit_fb;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbif_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cbif_pkg::ST_GEOM;
            end
         end
         cbif_pkg::ST_GEOM: begin
            state_in = status.nobox ? cbif_pkg::ST_DECIDE : cbif_pkg::ST_INTER;
         end
         cbif_pkg::ST_INTER: state_in = cbif_pkg::ST_BOX;
         cbif_pkg::ST_BOX:   state_in = cbif_pkg::ST_CROP;
         cbif_pkg::ST_CROP:  state_in = cbif_pkg::ST_UNION;
         cbif_pkg::ST_UNION: state_in = cbif_pkg::ST_TLO;
         cbif_pkg::ST_TLO:   state_in = cbif_pkg::ST_THI;
         cbif_pkg::ST_THI:   state_in = cbif_pkg::ST_CMP;
         cbif_pkg::ST_CMP:   state_in = cbif_pkg::ST_DECIDE;
         cbif_pkg::ST_DECIDE: begin
            if (!need_out || out_free) begin
               state_in = cbif_pkg::ST_IDLE;
            end
         end
         default: state_in = cbif_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '{load_in: 1'b0, op: cbif_pkg::OP_NONE, load_out: 1'b0, fallback: 1'b0};
      req_ready    = 1'b0;
      any_kept_in  = any_kept_ff;
      unique case (state_ff)
         cbif_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         cbif_pkg::ST_GEOM:  cmd.op = cbif_pkg::OP_GEOM;
         cbif_pkg::ST_INTER: cmd.op = cbif_pkg::OP_INTER;
         cbif_pkg::ST_BOX:   cmd.op = cbif_pkg::OP_BOX;
         cbif_pkg::ST_CROP:  cmd.op = cbif_pkg::OP_CROP;
         cbif_pkg::ST_UNION: cmd.op = cbif_pkg::OP_UNION;
         cbif_pkg::ST_TLO:   cmd.op = cbif_pkg::OP_TLO;
         cbif_pkg::ST_THI:   cmd.op = cbif_pkg::OP_THI;
         cbif_pkg::ST_CMP:   cmd.op = cbif_pkg::OP_CMP;
         cbif_pkg::ST_DECIDE: begin
            if (!need_out || out_free) begin
               cmd.load_out = need_out;
               cmd.fallback = emit_fb;
               if (emit_kept) begin
                  any_kept_in = !status.last;
               end else if (status.last) begin
                  any_kept_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbif_pkg::ST_IDLE;
         any_kept_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         any_kept_ff  <= any_kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
